// ===== src/fpmc_pkg.sv =====
// Shared constants, tables and types for the feedback phase-modulated cosine unit.
// Used by fpmc_cordic and feedback_phase_mod_cosine_unit; depends on nothing else.
package fpmc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SAMPLE_BITS  = 16;

    localparam int FRAC_BITS   = SAMPLE_BITS + 4;
    // Sign, two integer bits and the fraction cover the CORDIC growth.
    localparam int XY_W        = FRAC_BITS + 3;
    localparam int Z_W         = 34;
    localparam int ANGLE_COUNT = 24;
    localparam int ANGLE_IDX_W = $clog2(ANGLE_COUNT);
    localparam int STEP_COUNT  = (CORDIC_STEPS < ANGLE_COUNT) ? CORDIC_STEPS : ANGLE_COUNT;

    localparam longint GAIN_Q30 = 652032875;
    localparam longint X_INIT_L =
        (GAIN_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam logic signed [XY_W-1:0] X_INIT = XY_W'(X_INIT_L);

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [ANGLE_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLED         = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIPOLAR         = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_AMOUNT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_PHASE,
        ST_ROT,
        ST_FIN
    } fpmc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fpmc_cordic_stat_t;

endpackage

// ===== src/fpmc_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on shared x, y, z registers.
// Depends on fpmc_pkg for widths, the start gain and the arctangent table.
module fpmc_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [15:0]                   angle,  // 2^-16 turn, within +-1/4 turn
    output logic signed [fpmc_pkg::XY_W-1:0]     cos_x,
    output fpmc_pkg::fpmc_cordic_stat_t          stat
);
    import fpmc_pkg::*;

    localparam logic [ANGLE_IDX_W-1:0] LAST_IDX = ANGLE_IDX_W'(STEP_COUNT - 1);

    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [ANGLE_IDX_W-1:0]   idx_reg, idx_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic signed [XY_W-1:0]   x_shift;
    logic signed [XY_W-1:0]   y_shift;
    logic signed [Z_W-1:0]    atan_ext;
    logic [31:0]              atan_word;

    assign x_shift   = x_reg >>> idx_reg;
    assign y_shift   = y_reg >>> idx_reg;
    assign atan_word = ATAN_TURNS[idx_reg];
    assign atan_ext  = {{(Z_W-32){1'b0}}, atan_word};

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = X_INIT;
            y_next    = '0;
            z_next    = {{(Z_W-32){angle[15]}}, angle, 16'b0};
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[Z_W-1]) begin
                x_next = x_reg - y_shift;
                y_next = y_reg + x_shift;
                z_next = z_reg - atan_ext;
            end else begin
                x_next = x_reg + y_shift;
                y_next = y_reg - x_shift;
                z_next = z_reg + atan_ext;
            end
            if (idx_reg == LAST_IDX) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        idx_reg <= idx_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign cos_x     = x_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`ifndef SYNTHESIS
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("CORDIC started while a rotation is in progress");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("CORDIC done without a finished rotation");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("CORDIC done held longer than one cycle");
`endif

endmodule

// ===== src/feedback_phase_mod_cosine_unit.sv =====
// Top level of the feedback phase-modulated cosine operator: stream ports, config registers,
// sequencer, feedback multiply and output stage. Depends on fpmc_pkg and fpmc_cordic.
//
//  Channel   Direction  Request moves                    Handshake
//  s_*       in         phase_in, feedback_mod           s_tvalid / s_tready
//  m_*       out        sample_out                       m_tvalid / m_tready
//  cfg_*     in         register index and value         cfg_wr_en, no wait
//
// Requests do not overlap: the next is accepted only after the current one has finished,
// and the single CORDIC unit does one micro-rotation per cycle.
// s_tready is high only while the sequencer is idle; a result sits in the output register
// while the next request is processed, and the sequencer waits before loading a new
// result until the previous one is taken. Reset restores enabled = 1, bipolar = 1,
// feedback amount 0 and a stored cosine of 0.
module feedback_phase_mod_cosine_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,   // [11:0] phase_in, [31:16] feedback_mod
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [15:0]                           m_tdata,   // [15:0] sample_out
    input  logic                                  cfg_wr_en,
    input  logic [fpmc_pkg::CFG_ADDR_W-1:0]       cfg_index,
    input  logic [fpmc_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fpmc_pkg::*;

    localparam logic signed [XY_W:0] ROUND_ADD = (XY_W+1)'(1) << (FRAC_BITS - 16);
    localparam logic signed [XY_W:0] C_MAX     = (XY_W+1)'(32767);
    localparam logic signed [XY_W:0] C_MIN     = -(XY_W+1)'(32767);

    fpmc_state_t state_reg, state_next;

    logic                         enabled_reg;
    logic                         bipolar_reg;
    logic [CFG_DATA_W-1:0]        amount_reg;
    logic signed [15:0]           last_cos_reg, last_cos_next;

    logic [11:0]                  phase_reg, phase_next;
    logic signed [15:0]           mod_reg, mod_next;
    logic signed [15:0]           fb_reg, fb_next;
    logic signed [31:0]           prod_reg, prod_next;
    logic signed [15:0]           angle_reg, angle_next;
    logic                         flip_reg, flip_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [15:0]                  m_tdata_reg, m_tdata_next;

    logic                         accept;
    logic                         cordic_start;
    logic                         out_load;

    logic signed [16:0]           fb_sum;
    logic [31:0]                  prod_rnd;
    logic [15:0]                  phase16;
    logic signed [15:0]           phase_s;
    logic                         flip_now;

    logic signed [XY_W-1:0]       cos_x;
    fpmc_cordic_stat_t            cordic_stat;
    logic signed [XY_W:0]         cos_rnd;
    logic signed [XY_W:0]         cos_sh;
    logic signed [15:0]           cos_sat;
    logic signed [15:0]           cos_final;
    logic [15:0]                  out_word;

    fpmc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (angle_next),
        .cos_x   (cos_x),
        .stat    (cordic_stat)
    );

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SUM;
            ST_SUM:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_PHASE;
            ST_PHASE: state_next = ST_ROT;
            ST_ROT:   if (cordic_stat.done) state_next = ST_FIN;
            ST_FIN:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_tready     = 1'b0;
        cordic_start = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_PHASE: cordic_start = 1'b1;
            ST_FIN:   out_load = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Feedback amount plus modulation; only positive overflow is possible.
    assign fb_sum = $signed({2'b00, amount_reg}) + $signed({mod_reg[15], mod_reg});

    // Product rounded to 2^-16 turn; the bits above a whole turn drop out.
    assign prod_rnd = prod_reg + 32'd4096;
    assign phase16  = {phase_reg, 4'b0000} + prod_rnd[28:13];
    assign phase_s  = phase16;
    assign flip_now = (phase_s > 16'sd16384) || (phase_s < -16'sd16384);

    // Round the CORDIC x to Q1.15, saturate, then undo the half-cycle move.
    assign cos_rnd   = $signed({cos_x[XY_W-1], cos_x}) + ROUND_ADD;
    assign cos_sh    = cos_rnd >>> (FRAC_BITS - 15);
    assign cos_sat   = (cos_sh > C_MAX) ? 16'sd32767 :
                       (cos_sh < C_MIN) ? -16'sd32767 : cos_sh[15:0];
    assign cos_final = flip_reg ? -cos_sat : cos_sat;

    always_comb begin
        if (!enabled_reg) begin
            out_word = '0;
        end else if (bipolar_reg) begin
            out_word = cos_final;
        end else begin
            out_word = {1'b0, ~cos_final[15], cos_final[14:1]};
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        mod_next      = mod_reg;
        fb_next       = fb_reg;
        prod_next     = prod_reg;
        angle_next    = angle_reg;
        flip_next     = flip_reg;
        last_cos_next = last_cos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            phase_next = s_tdata[11:0];
            mod_next   = s_tdata[31:16];
        end
        if (state_reg == ST_SUM) begin
            fb_next = (!fb_sum[16] && fb_sum[15]) ? 16'sd32767 : fb_sum[15:0];
        end
        if (state_reg == ST_MUL) begin
            prod_next = fb_reg * last_cos_reg;
        end
        if (state_reg == ST_PHASE) begin
            flip_next  = flip_now;
            angle_next = flip_now ? {~phase16[15], phase16[14:0]} : phase16;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            last_cos_next = cos_final;
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_word;
        end
    end

    // Datapath registers need no reset; each is written before it is read.
    always_ff @(posedge aclk) begin
        phase_reg   <= phase_next;
        mod_reg     <= mod_next;
        fb_reg      <= fb_next;
        prod_reg    <= prod_next;
        flip_reg    <= flip_next;
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            last_cos_reg <= '0;
            enabled_reg  <= 1'b1;
            bipolar_reg  <= 1'b1;
            amount_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            last_cos_reg <= last_cos_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENABLED:         enabled_reg <= cfg_data[0];
                    REG_BIPOLAR:         bipolar_reg <= cfg_data[0];
                    REG_FEEDBACK_AMOUNT: amount_reg  <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // The CORDIC samples its angle on the start edge, so the angle is presented
    // combinationally during ST_PHASE and held in angle_reg afterwards.
    always_ff @(posedge aclk) begin
        angle_reg <= angle_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_ready_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cordic_stat.busy)
        else $error("Input ready while the CORDIC is rotating");

    a_done_in_rot: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_stat.done |-> state_reg == ST_ROT)
        else $error("CORDIC finished outside the rotation wait");

    a_no_min_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("Output reached the excluded most negative code");

    a_disabled_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && !enabled_reg |-> m_tdata == 16'h0000)
        else $error("Nonzero output while disabled");
`endif

endmodule
